@@ src/mpool_pkg.sv @@
// ----------------------------------------------------------------------------
// mpool_pkg
// Shared types and constants of the streaming max-pool block.
// ----------------------------------------------------------------------------
package mpool_pkg;

   localparam int DATA_W = 16;
   localparam int FRAC   = 20;

   localparam logic [2:0] CSR_IN_HEIGHT   = 3'd0;
   localparam logic [2:0] CSR_IN_WIDTH    = 3'd1;
   localparam logic [2:0] CSR_CHANNELS    = 3'd2;
   localparam logic [2:0] CSR_KERNEL_SIZE = 3'd3;
   localparam logic [2:0] CSR_STRIDE      = 3'd4;
   localparam logic [2:0] CSR_PAD         = 3'd5;

   typedef logic signed [13:0] sidx_type;

   // clamped geometry
   typedef struct packed {
      logic [10:0] h;
      logic [10:0] w;
      logic [10:0] ch;
      logic [3:0]  k;
      logic [3:0]  s;
      logic [2:0]  p;
   } geo_type;

   // one classified sample, handed from front to back
   typedef struct packed {
      logic signed [DATA_W-1:0] v;
      logic [9:0]  chan;
      logic [9:0]  r;
      logic [10:0] x;
      logic [11:0] jlo;
      logic [11:0] jhi;
      logic [11:0] ilo;
      logic [11:0] ihi;
      sidx_type    rs0;
      sidx_type    cs0;
      logic [3:0]  jm;
   } cmd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pooled;
      logic [9:0]  chan;
      logic [10:0] row;
      logic [10:0] col;
      logic        last;
   } res_type;

   // ceil(2^FRAC / s) for s = 1..8
   function automatic logic [20:0] s_recip(input logic [3:0] s);
      logic [20:0] r;
      case (s)
         4'd1:    r = 21'd1048576;
         4'd2:    r = 21'd524288;
         4'd3:    r = 21'd349526;
         4'd4:    r = 21'd262144;
         4'd5:    r = 21'd209716;
         4'd6:    r = 21'd174763;
         4'd7:    r = 21'd149797;
         default: r = 21'd131072;
      endcase
      return r;
   endfunction

   // floor(num / s) by reciprocal multiply, exact for num < 4096
   function automatic logic [11:0] div_small(input logic [11:0] num, input logic [3:0] s);
      logic [32:0] prod;
      prod = {21'd0, num} * {12'd0, s_recip(s)};
      return prod[FRAC +: 12];
   endfunction

endpackage

@@ src/mpool_fifo.sv @@
// ----------------------------------------------------------------------------
// mpool_fifo
// Small synchronous queue of packed words.
// ----------------------------------------------------------------------------
module mpool_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wp_ff, rp_ff;
   logic [CW-1:0]    cnt_ff;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem[rp_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wp_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wp_ff <= (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         end
         if (do_pop) begin
            rp_ff <= (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end
endmodule

@@ src/mpool_front.sv @@
// ----------------------------------------------------------------------------
// mpool_front
// Accepts samples, tracks the raster position and finds the window range.
// ----------------------------------------------------------------------------
module mpool_front import mpool_pkg::*; #(
   parameter int MAX_KERNEL = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  geo_type                  geo,
   input  logic                     req_push,
   input  logic signed [DATA_W-1:0] req_sample,
   output logic                     req_full,
   output logic                     cq_push,
   output cmd_type                  cq_data,
   input  logic                     cq_full
);
   localparam logic [20:0] MK_RECIP = 21'(((1 << FRAC) + MAX_KERNEL - 1) / MAX_KERNEL);

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_FIN, F_PUSH} fstate_type;
   fstate_type st_ff;

   logic [10:0] col_ff;
   logic [9:0]  row_ff, chan_ff;
   logic signed [DATA_W-1:0] v_ff;
   logic [9:0]  r_ff, c_ff;
   logic [10:0] x_ff;
   logic [11:0] num_ff [4];
   logic [11:0] q_ff [4];
   sidx_type    oh_ff, ow_ff;
   logic [11:0] jlo_ff, jhi_ff, ilo_ff, ihi_ff;
   sidx_type    rs0_ff, cs0_ff;
   logic [32:0] mk_ff;
   logic        have_ff;

   sidx_type    rp, xp, lo_r, lo_c, span_h, span_w, jhi_s, ihi_s;
   sidx_type    jm_s;
   logic        accept;
   logic [11:0] col_in;
   logic [10:0] row_in;
   logic [10:0] chan_in;

   assign accept   = (st_ff == F_IDLE) && req_push;
   assign req_full = (st_ff != F_IDLE);

   always_comb begin
      rp     = sidx_type'(row_ff) + sidx_type'(geo.p);
      xp     = sidx_type'(col_ff) + sidx_type'(geo.p);
      lo_r   = rp - sidx_type'(geo.k) + 14'sd1;
      lo_c   = xp - sidx_type'(geo.k) + 14'sd1;
      if (lo_r < 0) lo_r = '0;
      if (lo_c < 0) lo_c = '0;
      lo_r   = lo_r + sidx_type'(geo.s) - 14'sd1;
      lo_c   = lo_c + sidx_type'(geo.s) - 14'sd1;
      span_h = sidx_type'(geo.h) + sidx_type'({geo.p, 1'b0}) - sidx_type'(geo.k);
      span_w = sidx_type'(geo.w) + sidx_type'({geo.p, 1'b0}) - sidx_type'(geo.k);
      jhi_s  = sidx_type'(q_ff[0]);
      ihi_s  = sidx_type'(q_ff[2]);
      if (jhi_s > oh_ff - 14'sd1) jhi_s = oh_ff - 14'sd1;
      if (ihi_s > ow_ff - 14'sd1) ihi_s = ow_ff - 14'sd1;
      jm_s   = sidx_type'(jlo_ff) - sidx_type'(mk_ff[FRAC +: 12] * 12'(MAX_KERNEL));
      col_in  = {1'b0, col_ff} + 12'd1;
      row_in  = {1'b0, row_ff} + 11'd1;
      chan_in = {1'b0, chan_ff} + 11'd1;
   end

   // output size tracks the configuration
   always_ff @(posedge clock) begin
      oh_ff <= (span_h < 0) ? '0 : sidx_type'(div_small(span_h[11:0], geo.s)) + 14'sd1;
      ow_ff <= (span_w < 0) ? '0 : sidx_type'(div_small(span_w[11:0], geo.s)) + 14'sd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= F_IDLE;
         col_ff  <= '0;
         row_ff  <= '0;
         chan_ff <= '0;
         have_ff <= 1'b0;
      end else begin
         case (st_ff)
            F_IDLE: begin
               if (accept) begin
                  v_ff      <= req_sample;
                  r_ff      <= row_ff;
                  x_ff      <= col_ff;
                  c_ff      <= chan_ff;
                  num_ff[0] <= rp[11:0];
                  num_ff[1] <= lo_r[11:0];
                  num_ff[2] <= xp[11:0];
                  num_ff[3] <= lo_c[11:0];
                  if (col_in >= {1'b0, geo.w}) begin
                     col_ff <= '0;
                     if (row_in >= geo.h) begin
                        row_ff  <= '0;
                        chan_ff <= (chan_in >= geo.ch) ? '0 : chan_in[9:0];
                     end else begin
                        row_ff <= row_in[9:0];
                     end
                  end else begin
                     col_ff <= col_in[10:0];
                  end
                  st_ff <= F_DIV;
               end
            end
            F_DIV: begin
               for (int n = 0; n < 4; n++) begin
                  q_ff[n] <= div_small(num_ff[n], geo.s);
               end
               st_ff <= F_FIN;
            end
            F_FIN: begin
               jlo_ff  <= q_ff[1];
               ilo_ff  <= q_ff[3];
               jhi_ff  <= jhi_s[11:0];
               ihi_ff  <= ihi_s[11:0];
               have_ff <= (sidx_type'(q_ff[1]) <= jhi_s) && (sidx_type'(q_ff[3]) <= ihi_s);
               mk_ff   <= {21'd0, q_ff[1]} * {12'd0, MK_RECIP};
               rs0_ff  <= sidx_type'(q_ff[1] * 12'(geo.s)) - sidx_type'(geo.p);
               cs0_ff  <= sidx_type'(q_ff[3] * 12'(geo.s)) - sidx_type'(geo.p);
               st_ff   <= F_PUSH;
            end
            F_PUSH: begin
               if (!have_ff || !cq_full) begin
                  st_ff <= F_IDLE;
               end
            end
            default: st_ff <= F_IDLE;
         endcase
      end
   end

   assign cq_push = (st_ff == F_PUSH) && have_ff && !cq_full;

   always_comb begin
      cq_data.v    = v_ff;
      cq_data.chan = c_ff;
      cq_data.r    = r_ff;
      cq_data.x    = x_ff;
      cq_data.jlo  = jlo_ff;
      cq_data.jhi  = jhi_ff;
      cq_data.ilo  = ilo_ff;
      cq_data.ihi  = ihi_ff;
      cq_data.rs0  = rs0_ff;
      cq_data.cs0  = cs0_ff;
      cq_data.jm   = jm_s[3:0];
   end
endmodule

@@ src/mpool_back.sv @@
// ----------------------------------------------------------------------------
// mpool_back
// Walks the open windows of one sample, updates running maxima, emits results.
// ----------------------------------------------------------------------------
module mpool_back import mpool_pkg::*; #(
   parameter int MAX_IN_WIDTH = 1024,
   parameter int MAX_KERNEL   = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  geo_type geo,
   input  logic    cq_empty,
   input  cmd_type cq_data,
   output logic    cq_pop,
   output logic    oq_push,
   output res_type oq_data,
   input  logic    oq_full
);
   localparam int ROW_SPAN = MAX_IN_WIDTH + 2 * (MAX_KERNEL - 1);
   localparam int DEPTH    = MAX_KERNEL * ROW_SPAN;
   localparam int AW       = $clog2(DEPTH);
   localparam int MAX_RES  = 64;

   typedef enum logic [1:0] {B_IDLE, B_READ, B_UPD, B_FLUSH} bstate_type;
   bstate_type st_ff;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_ff;
   cmd_type     cmd_ff;
   logic [11:0] j_ff, i_ff;
   logic [3:0]  jm_ff;
   sidx_type    rs_ff, cs_ff;
   logic [6:0]  n_ff;
   logic        pend_ff;
   res_type     pend_res_ff;

   logic [AW-1:0] addr;
   sidx_type    rfirst, rlast, cfirst, clast, r_s, x_s;
   logic        first_hit, emit, stall, wr_en;
   logic signed [DATA_W-1:0] m_val;

   assign addr = AW'(jm_ff) * AW'(ROW_SPAN) + AW'(i_ff);

   always_comb begin
      r_s    = sidx_type'(cmd_ff.r);
      x_s    = sidx_type'(cmd_ff.x);
      rfirst = (rs_ff < 0) ? '0 : rs_ff;
      cfirst = (cs_ff < 0) ? '0 : cs_ff;
      rlast  = rs_ff + sidx_type'(geo.k) - 14'sd1;
      clast  = cs_ff + sidx_type'(geo.k) - 14'sd1;
      if (rlast > sidx_type'(geo.h) - 14'sd1) rlast = sidx_type'(geo.h) - 14'sd1;
      if (clast > sidx_type'(geo.w) - 14'sd1) clast = sidx_type'(geo.w) - 14'sd1;
      first_hit = (r_s == rfirst) && (x_s == cfirst);
      m_val     = (first_hit || cmd_ff.v > rd_ff) ? cmd_ff.v : rd_ff;
      emit      = (r_s == rlast) && (x_s == clast) && (n_ff < 7'(MAX_RES));
      stall     = emit && pend_ff && oq_full;
      wr_en     = (st_ff == B_UPD) && !stall;
   end

   assign cq_pop  = (st_ff == B_IDLE) && !cq_empty;
   assign oq_push = pend_ff && !oq_full &&
                    (((st_ff == B_UPD) && emit) || (st_ff == B_FLUSH));

   always_comb begin
      oq_data      = pend_res_ff;
      oq_data.last = (st_ff == B_FLUSH);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= m_val;
      end
      if (st_ff == B_READ) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= B_IDLE;
         pend_ff <= 1'b0;
      end else begin
         case (st_ff)
            B_IDLE: begin
               if (!cq_empty) begin
                  cmd_ff  <= cq_data;
                  j_ff    <= cq_data.jlo;
                  i_ff    <= cq_data.ilo;
                  jm_ff   <= cq_data.jm;
                  rs_ff   <= cq_data.rs0;
                  cs_ff   <= cq_data.cs0;
                  n_ff    <= '0;
                  pend_ff <= 1'b0;
                  st_ff   <= B_READ;
               end
            end
            B_READ: st_ff <= B_UPD;
            B_UPD: begin
               if (!stall) begin
                  if (emit) begin
                     pend_ff            <= 1'b1;
                     pend_res_ff.pooled <= m_val;
                     pend_res_ff.chan   <= cmd_ff.chan;
                     pend_res_ff.row    <= j_ff[10:0];
                     pend_res_ff.col    <= i_ff[10:0];
                     pend_res_ff.last   <= 1'b0;
                     n_ff               <= n_ff + 7'd1;
                  end
                  if (i_ff < cmd_ff.ihi) begin
                     i_ff  <= i_ff + 12'd1;
                     cs_ff <= cs_ff + sidx_type'(geo.s);
                     st_ff <= B_READ;
                  end else if (j_ff < cmd_ff.jhi) begin
                     j_ff  <= j_ff + 12'd1;
                     i_ff  <= cmd_ff.ilo;
                     cs_ff <= cmd_ff.cs0;
                     rs_ff <= rs_ff + sidx_type'(geo.s);
                     jm_ff <= (jm_ff == 4'(MAX_KERNEL - 1)) ? '0 : jm_ff + 4'd1;
                     st_ff <= B_READ;
                  end else begin
                     st_ff <= B_FLUSH;
                  end
               end
            end
            B_FLUSH: begin
               if (!pend_ff || !oq_full) begin
                  pend_ff <= 1'b0;
                  st_ff   <= B_IDLE;
               end
            end
            default: st_ff <= B_IDLE;
         endcase
      end
   end
endmodule

@@ src/padded_max_pool_stream.sv @@
// ----------------------------------------------------------------------------
// padded_max_pool_stream
// Streaming 2-D max pooling with square window, stride and border padding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a Q8.8 sample is taken on a beat with req_push high and
//   req_full low. Samples come in raster order, one channel after another.
//   Result channel: while rsp_empty is low the oldest pooled result sits on
//   the rsp_ ports; a beat with rsp_pop high retires it. rsp_group_last
//   marks the final result caused by one sample.
//   Configuration: csr_ready is always high; write registers only while idle.
// Flow:
//   The front handles one sample at a time: take and position update,
//   reciprocal divide, range clamp, queue hand-off; it takes no new sample
//   until the hand-off is done. The back takes a command, then for each open
//   window does a registered memory read and then an update, and ends with a
//   flush; a sample touches up to ceil(k/s)^2 windows.
// Reset:
//   Synchronous; clears positions, queues and loads the default geometry.
//   Running maxima are not cleared: a window's first pixel initializes it.
// Stall:
//   A held result backs up the result queue, then the back, then the
//   command queue, and finally raises req_full.
// ----------------------------------------------------------------------------
module padded_max_pool_stream import mpool_pkg::*; #(
   parameter int MAX_IN_WIDTH = 1024,
   parameter int MAX_KERNEL   = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  logic signed [DATA_W-1:0] req_sample,
   output logic                     req_full,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [DATA_W-1:0] rsp_pooled,
   output logic [9:0]               rsp_chan_index,
   output logic [10:0]              rsp_out_row,
   output logic [10:0]              rsp_out_col,
   output logic                     rsp_group_last,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [10:0]              csr_data
);
   // largest usable width and kernel given the register field sizes
   localparam int WCAP = (MAX_IN_WIDTH > 2047) ? 2047 : MAX_IN_WIDTH;
   localparam int KCAP = (MAX_KERNEL > 15) ? 15 : MAX_KERNEL;

   logic [10:0] in_height_ff, in_width_ff, channels_ff;
   logic [3:0]  kernel_size_ff, stride_ff;
   logic [2:0]  pad_ff;
   geo_type     geo;

   logic        cq_push, cq_full, cq_pop, cq_empty;
   cmd_type     cq_in, cq_out;
   logic        oq_push, oq_full;
   res_type     oq_in, oq_out;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff   <= 11'd1;
         in_width_ff    <= 11'd1;
         channels_ff    <= 11'd1;
         kernel_size_ff <= 4'd2;
         stride_ff      <= 4'd2;
         pad_ff         <= 3'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IN_HEIGHT:   in_height_ff   <= csr_data;
            CSR_IN_WIDTH:    in_width_ff    <= csr_data;
            CSR_CHANNELS:    channels_ff    <= csr_data;
            CSR_KERNEL_SIZE: kernel_size_ff <= csr_data[3:0];
            CSR_STRIDE:      stride_ff      <= csr_data[3:0];
            CSR_PAD:         pad_ff         <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // clamp every register into its working range; pad never reaches k
   always_comb begin
      geo.h  = (in_height_ff == '0) ? 11'd1 :
               (in_height_ff > 11'd1024) ? 11'd1024 : in_height_ff;
      geo.w  = (in_width_ff == '0) ? 11'd1 :
               (in_width_ff > 11'(WCAP)) ? 11'(WCAP) : in_width_ff;
      geo.ch = (channels_ff == '0) ? 11'd1 :
               (channels_ff > 11'd1024) ? 11'd1024 : channels_ff;
      geo.k  = (kernel_size_ff == '0) ? 4'd1 :
               (kernel_size_ff > 4'(KCAP)) ? 4'(KCAP) : kernel_size_ff;
      geo.s  = (stride_ff == '0) ? 4'd1 : (stride_ff > 4'd8) ? 4'd8 : stride_ff;
      geo.p  = ({1'b0, pad_ff} > geo.k - 4'd1) ? 3'(geo.k - 4'd1) : pad_ff;
   end

   // front: accept, track position, find window range
   mpool_front #(
      .MAX_KERNEL (MAX_KERNEL)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .geo        (geo),
      .req_push   (req_push),
      .req_sample (req_sample),
      .req_full   (req_full),
      .cq_push    (cq_push),
      .cq_data    (cq_in),
      .cq_full    (cq_full)
   );

   // decouple front and back
   mpool_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cq_push),
      .din   (cq_in),
      .full  (cq_full),
      .pop   (cq_pop),
      .dout  (cq_out),
      .empty (cq_empty)
   );

   // back: walk windows, update maxima, emit results
   mpool_back #(
      .MAX_IN_WIDTH (MAX_IN_WIDTH),
      .MAX_KERNEL   (MAX_KERNEL)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .geo      (geo),
      .cq_empty (cq_empty),
      .cq_data  (cq_out),
      .cq_pop   (cq_pop),
      .oq_push  (oq_push),
      .oq_data  (oq_in),
      .oq_full  (oq_full)
   );

   // result queue faces the receiver
   mpool_fifo #(
      .WIDTH ($bits(res_type)),
      .DEPTH (4)
   ) u_res_q (
      .clock (clock),
      .reset (reset),
      .push  (oq_push),
      .din   (oq_in),
      .full  (oq_full),
      .pop   (rsp_pop),
      .dout  (oq_out),
      .empty (rsp_empty)
   );

   assign rsp_pooled     = oq_out.pooled;
   assign rsp_chan_index = oq_out.chan;
   assign rsp_out_row    = oq_out.row;
   assign rsp_out_col    = oq_out.col;
   assign rsp_group_last = oq_out.last;
endmodule
